@@ hw/rtl/bgc_pkg.sv @@
// Shared types and constants for the button gesture classifier.
// No dependencies; imported by every other RTL file of the block.
`default_nettype none

package bgc_pkg;

  localparam int unsigned StampW   = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned GestureW = 3;
  localparam int unsigned TallyW   = 3;
  localparam int unsigned RegIdxW  = 2;

  typedef logic [StampW-1:0]   stamp_t;
  typedef logic [CfgW-1:0]     cfg_word_t;
  typedef logic [GestureW-1:0] gesture_t;
  typedef logic [TallyW-1:0]   tally_t;
  typedef logic [RegIdxW-1:0]  reg_idx_t;

  // configuration register indexes
  localparam reg_idx_t REG_DEBOUNCE   = 2'd0;
  localparam reg_idx_t REG_LONG_PRESS = 2'd1;
  localparam reg_idx_t REG_CLICK_GAP  = 2'd2;

  localparam cfg_word_t DEBOUNCE_RESET   = 16'd50;
  localparam cfg_word_t LONG_PRESS_RESET = 16'd1000;
  localparam cfg_word_t CLICK_GAP_RESET  = 16'd300;

  // gesture codes; click codes equal the click count
  localparam gesture_t GESTURE_NONE = 3'd0;
  localparam gesture_t GESTURE_LONG = 3'd4;

  localparam tally_t TALLY_MAX  = 3'd7;
  localparam tally_t MAX_CLICKS = 3'd3;

  typedef struct packed {
    cfg_word_t debounce_ms;
    cfg_word_t long_press_ms;
    cfg_word_t click_gap_ms;
  } bgc_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/bgc_if.sv @@
// Valid/ready channel interfaces of the button gesture classifier:
// sample input, gesture result and configuration write. Uses bgc_pkg.
`default_nettype none

interface bgc_sample_if
  import bgc_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   raw_level;
  stamp_t now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bgc_result_if
  import bgc_pkg::*;
();
  logic     valid;
  logic     ready;
  gesture_t gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface

interface bgc_cfg_if
  import bgc_pkg::*;
();
  logic      valid;
  logic      ready;
  reg_idx_t  index;
  cfg_word_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bgc_cfg_regs.sv @@
// Configuration register file: debounce, long-press and click-gap times.
// Depends on bgc_pkg and bgc_cfg_if.
`default_nettype none

module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  bgc_cfg_if.sink   cfg,
  output bgc_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms   <= DEBOUNCE_RESET;
      regs.long_press_ms <= LONG_PRESS_RESET;
      regs.click_gap_ms  <= CLICK_GAP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEBOUNCE:   regs.debounce_ms   <= cfg.data;
        REG_LONG_PRESS: regs.long_press_ms <= cfg.data;
        REG_CLICK_GAP:  regs.click_gap_ms  <= cfg.data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bgc_core.sv @@
// Debounce, press tally and gesture decision for one sample per cycle with load high.
// Holds the classifier state. Depends on bgc_pkg.
`default_nettype none

module bgc_core
  import bgc_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       load,
  input  wire       level,
  input  stamp_t    now,
  input  bgc_cfg_t  regs,
  output gesture_t  gesture
);

  logic   prev_raw, prev_raw_next;
  logic   stable_level, stable_level_next;
  stamp_t change_stamp, change_stamp_next;
  tally_t press_tally, press_tally_next;
  stamp_t last_press_stamp, last_press_stamp_next;
  logic   holding, holding_next;
  stamp_t hold_start_stamp, hold_start_stamp_next;

  logic   raw_changed;
  logic   stable_edge;
  logic   press;
  logic   hold_start;
  logic   long_hit;
  logic   gap_hit;
  stamp_t since_change;
  stamp_t since_hold;
  stamp_t since_press;
  tally_t tally_upd;

  always_comb begin
    raw_changed = (level != prev_raw);
    // restamped values read as zero elapsed time
    since_change = raw_changed ? '0 : now - change_stamp;
    stable_edge  = (since_change > {16'd0, regs.debounce_ms}) && (level != stable_level);
    press        = stable_edge && !level;
    hold_start   = press && !holding;

    prev_raw_next         = level;
    change_stamp_next     = raw_changed ? now : change_stamp;
    stable_level_next     = stable_edge ? level : stable_level;
    last_press_stamp_next = press ? now : last_press_stamp;
    hold_start_stamp_next = hold_start ? now : hold_start_stamp;

    if (press && press_tally != TALLY_MAX) begin
      tally_upd = press_tally + 3'd1;
    end else begin
      tally_upd = press_tally;
    end

    if (stable_edge) begin
      holding_next = !level;
    end else begin
      holding_next = holding;
    end

    since_hold  = hold_start ? '0 : now - hold_start_stamp;
    since_press = press ? '0 : now - last_press_stamp;
    long_hit    = holding_next && (since_hold > {16'd0, regs.long_press_ms});
    gap_hit     = (since_press > {16'd0, regs.click_gap_ms}) && (tally_upd != '0);

    press_tally_next = tally_upd;
    gesture          = GESTURE_NONE;
    priority if (long_hit) begin
      holding_next     = 1'b0;
      press_tally_next = '0;
      gesture          = GESTURE_LONG;
    end else if (gap_hit) begin
      press_tally_next = '0;
      if (!holding_next && tally_upd <= MAX_CLICKS) begin
        gesture = gesture_t'(tally_upd);
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw         <= 1'b1;
      stable_level     <= 1'b1;
      change_stamp     <= '0;
      press_tally      <= '0;
      last_press_stamp <= '0;
      holding          <= 1'b0;
      hold_start_stamp <= '0;
    end else if (load) begin
      prev_raw         <= prev_raw_next;
      stable_level     <= stable_level_next;
      change_stamp     <= change_stamp_next;
      press_tally      <= press_tally_next;
      last_press_stamp <= last_press_stamp_next;
      holding          <= holding_next;
      hold_start_stamp <= hold_start_stamp_next;
    end
  end

  // a held press always sits on a pressed stable level
  a_hold_pressed: assert property (@(posedge clk) disable iff (rst)
    holding |-> !stable_level)
    else $error("holding set while stable level released");

  a_long_clears: assert property (@(posedge clk) disable iff (rst)
    load && long_hit |=> press_tally == '0 && !holding)
    else $error("long press left tally or hold set");

  a_press_stamp: assert property (@(posedge clk) disable iff (rst)
    load && press |=> last_press_stamp == $past(now))
    else $error("press time stamp not captured");

endmodule

`default_nettype wire

@@ hw/rtl/button_gesture_classifier.sv @@
// Button gesture classifier: debounces an active-low button level and
// reports single, double, triple clicks and long presses.
//
// Channels: sample (raw_level, now_ms) in, result (gesture) out, and cfg,
// a register write port (index 0 debounce_ms, 1 long_press_ms,
// 2 click_gap_ms; other indexes are dropped). cfg is always ready.
// Every sample beat yields exactly one result beat; gesture 0 means none.
// An accepted sample sits in the input register; its gesture is then registered.
// Throughput: one sample per cycle unless result stalls; the state update is
// one pass of subtract/compare logic between the input and result registers.
// When result is stalled the input register holds one more sample and then
// sample.ready drops; nothing is lost or repeated.
// Reset (rst, synchronous) empties both registers, loads the default times
// (50, 1000, 300 ms) and returns the detector to released with no presses.
// Depends on bgc_pkg, bgc_if, bgc_cfg_regs and bgc_core.
`default_nettype none

module button_gesture_classifier
  import bgc_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  bgc_sample_if.sink   sample,
  bgc_result_if.source result,
  bgc_cfg_if.sink      cfg
);

  logic     q_valid;
  logic     q_level;
  stamp_t   q_now;
  logic     res_valid;
  gesture_t res_gesture;
  logic     advance;
  gesture_t gesture;
  bgc_cfg_t regs;

  assign advance        = !res_valid || result.ready;
  assign sample.ready   = !q_valid || advance;
  assign result.valid   = res_valid;
  assign result.gesture = res_gesture;

  bgc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bgc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && q_valid),
    .level   (q_level),
    .now     (q_now),
    .regs    (regs),
    .gesture (gesture)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (sample.ready) begin
      q_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      q_level <= sample.raw_level;
      q_now   <= sample.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      res_gesture <= gesture;
    end
  end

  a_q_held: assert property (@(posedge clk) disable iff (rst)
    q_valid && !advance |=> q_valid && $stable(q_now) && $stable(q_level))
    else $error("stalled sample lost from input register");

  a_res_loaded: assert property (@(posedge clk) disable iff (rst)
    q_valid && advance |=> res_valid)
    else $error("processed sample produced no result beat");

  a_gesture_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_gesture <= GESTURE_LONG)
    else $error("gesture code out of range");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Testbench for button_gesture_classifier: directed rows, then random click,
// hold and bounce sequences under several timing settings, all checked per beat.
// Depends on bgc_pkg, the bgc_if channel interfaces and the block itself.
`timescale 1ns / 100ps

module testbench
  import bgc_pkg::*;
;

  localparam int          NUM_PROBES  = 25;
  localparam int          NUM_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          MAX_REPORTS = 10;

  localparam reg_idx_t REG_UNUSED   = 2'd3;
  localparam gesture_t CLICK_SINGLE = 3'd1;
  localparam gesture_t CLICK_DOUBLE = 3'd2;
  localparam gesture_t CLICK_TRIPLE = 3'd3;

  typedef struct packed {
    logic     level;
    stamp_t   now;
    logic     pinned;   // want is typed in; otherwise the predictor decides
    gesture_t want;
  } probe_t;

  // default timing after reset: 50 ms debounce, 1000 ms long press, 300 ms gap
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{1'b1, 32'd0,          1'b1, GESTURE_NONE},  // right after reset
    '{1'b0, 32'd100,        1'b0, GESTURE_NONE},  // single click
    '{1'b0, 32'd151,        1'b0, GESTURE_NONE},
    '{1'b1, 32'd200,        1'b0, GESTURE_NONE},
    '{1'b1, 32'd251,        1'b0, GESTURE_NONE},
    '{1'b1, 32'd452,        1'b0, GESTURE_NONE},
    '{1'b0, 32'd500,        1'b0, GESTURE_NONE},  // long press
    '{1'b0, 32'd551,        1'b0, GESTURE_NONE},
    '{1'b0, 32'd1552,       1'b1, GESTURE_LONG},
    '{1'b1, 32'd1600,       1'b0, GESTURE_NONE},
    '{1'b1, 32'd1651,       1'b0, GESTURE_NONE},
    '{1'b0, 32'd1700,       1'b0, GESTURE_NONE},  // gap expires while held
    '{1'b0, 32'd1751,       1'b0, GESTURE_NONE},
    '{1'b0, 32'd2052,       1'b1, GESTURE_NONE},
    '{1'b1, 32'd2100,       1'b0, GESTURE_NONE},
    '{1'b1, 32'd2151,       1'b0, GESTURE_NONE},
    '{1'b0, 32'hFFFF_FFFF,  1'b0, GESTURE_NONE},  // press across the stamp wrap
    '{1'b0, 32'h0000_0040,  1'b0, GESTURE_NONE},
    '{1'b1, 32'h0000_0050,  1'b0, GESTURE_NONE},
    '{1'b1, 32'h0000_0090,  1'b0, GESTURE_NONE},
    '{1'b0, 32'd445,        1'b0, GESTURE_NONE},  // click reported on a raw change
    '{1'b0, 32'd496,        1'b0, GESTURE_NONE},  // settles only if level was kept
    '{1'b0, 32'h0000_0020,  1'b1, GESTURE_LONG},  // stamp jumps back
    '{1'b1, 32'h0000_0010,  1'b0, GESTURE_NONE},
    '{1'b1, 32'h0000_0070,  1'b0, GESTURE_NONE}
  };

  logic clk;
  logic rst;

  bgc_sample_if sample_ch ();
  bgc_result_if result_ch ();
  bgc_cfg_if    cfg_ch ();

  button_gesture_classifier u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // detector copy
  bgc_cfg_t times_cfg;
  logic     seen_raw;
  logic     stable_lvl;
  stamp_t   raw_changed_at;
  tally_t   tally;
  stamp_t   last_press_at;
  logic     held;
  stamp_t   held_since;

  gesture_t    gestures_due [$];
  logic        pin_on;
  gesture_t    pin_want;
  logic        calm;
  stamp_t      t_ms;
  int unsigned samples_taken;
  int unsigned reg_writes;
  int unsigned errors;
  int unsigned cycles;
  int unsigned gesture_hits [8];

  function automatic stamp_t age(stamp_t now, stamp_t since);
    return now - since;
  endfunction

  function automatic gesture_t predict_gesture(logic level, stamp_t now);
    tally_t n;
    if (level != seen_raw) raw_changed_at = now;
    seen_raw = level;
    if (age(now, raw_changed_at) > stamp_t'(times_cfg.debounce_ms) &&
        level != stable_lvl) begin
      stable_lvl = level;
      if (!level) begin
        if (tally < TALLY_MAX) tally = tally + 3'd1;
        last_press_at = now;
        if (!held) begin
          held       = 1'b1;
          held_since = now;
        end
      end else begin
        held = 1'b0;
      end
    end
    // a long press wins over clicks and drops the count
    if (held && age(now, held_since) > stamp_t'(times_cfg.long_press_ms)) begin
      held  = 1'b0;
      tally = '0;
      return GESTURE_LONG;
    end
    if (age(now, last_press_at) > stamp_t'(times_cfg.click_gap_ms) && tally != '0) begin
      n     = tally;
      tally = '0;
      if (!held && n <= MAX_CLICKS) return gesture_t'(n);
    end
    return GESTURE_NONE;
  endfunction

  function automatic int unsigned draw_pause();
    if (calm) return 0;
    return $urandom_range(0, 1) ? $urandom_range(0, 17) : 0;
  endfunction

  // at or just past a threshold, somewhat beyond it, or anywhere from 0 to one past it
  function automatic int unsigned near_limit(int unsigned lim);
    case ($urandom_range(0, 3))
      0:       return lim;
      1:       return lim + 1;
      2:       return lim + $urandom_range(2, 40);
      default: return $urandom_range(0, lim + 1);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_sample(input logic level, input stamp_t now);
    int unsigned pause;
    pause = draw_pause();
    if (pause != 0) begin
      sample_ch.valid = 1'b0;
      repeat (pause) @(negedge clk);
    end
    sample_ch.valid     = 1'b1;
    sample_ch.raw_level = level;
    sample_ch.now_ms    = now;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    if ($urandom_range(0, 49) == 0) calm = !calm;
  endtask

  task automatic step_to(input logic level, input int unsigned delta);
    t_ms = t_ms + stamp_t'(delta);
    send_sample(level, t_ms);
  endtask

  // presses with debounce, optional bounce and holds, then a quiet gap
  task automatic play_gesture();
    int unsigned db;
    int unsigned lp;
    int unsigned gap;
    int unsigned presses;
    int unsigned p;
    db      = 32'(times_cfg.debounce_ms);
    lp      = 32'(times_cfg.long_press_ms);
    gap     = 32'(times_cfg.click_gap_ms);
    presses = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
    for (p = 0; p < presses; p++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) step_to(1'($urandom_range(0, 1)), $urandom_range(0, db));
      step_to(1'b0, $urandom_range(1, 20));
      step_to(1'b0, near_limit(db));
      if ($urandom_range(0, 5) == 0)
        step_to(1'b0, near_limit(lp));
      else if ($urandom_range(0, 1))
        step_to(1'b0, $urandom_range(0, lp));
      step_to(1'b1, $urandom_range(1, 20));
      step_to(1'b1, near_limit(db));
    end
    step_to(1'b1, near_limit(gap));
    if ($urandom_range(0, 1)) step_to(1'b1, near_limit(gap));
  endtask

  task automatic write_reg(input reg_idx_t idx, input cfg_word_t value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_DEBOUNCE:   times_cfg.debounce_ms   = value;
      REG_LONG_PRESS: times_cfg.long_press_ms = value;
      REG_CLICK_GAP:  times_cfg.click_gap_ms  = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_ch.valid = 1'b0;
    while (gestures_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // result side back-pressure
  initial begin
    int unsigned pause;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      pause = draw_pause();
      if (pause != 0) begin
        result_ch.ready = 1'b0;
        repeat (pause) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    gesture_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (gestures_due.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("unexpected gesture beat: got %0d", result_ch.gesture);
          errors++;
        end else begin
          want = gestures_due.pop_front();
          if (result_ch.gesture !== want) begin
            if (errors < MAX_REPORTS)
              $display("gesture mismatch: expected %0d, got %0d", want, result_ch.gesture);
            errors++;
          end
        end
        gesture_hits[result_ch.gesture]++;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        want = predict_gesture(sample_ch.raw_level, sample_ch.now_ms);
        if (pin_on) want = pin_want;
        gestures_due.push_back(want);
        samples_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    bgc_cfg_t    next_times;
    int          ph;
    int unsigned phase_end;
    int unsigned db;
    rst                 = 1'b1;
    sample_ch.valid     = 1'b0;
    sample_ch.raw_level = 1'b1;
    sample_ch.now_ms    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_DEBOUNCE;
    cfg_ch.data         = '0;
    times_cfg           = '{DEBOUNCE_RESET, LONG_PRESS_RESET, CLICK_GAP_RESET};
    seen_raw            = 1'b1;
    stable_lvl          = 1'b1;
    raw_changed_at      = '0;
    tally               = '0;
    last_press_at       = '0;
    held                = 1'b0;
    held_since          = '0;
    pin_on              = 1'b0;
    pin_want            = GESTURE_NONE;
    calm                = 1'b0;
    t_ms                = '0;
    samples_taken       = 0;
    reg_writes          = 0;
    errors              = 0;
    cycles              = 0;
    foreach (gesture_hits[i]) gesture_hits[i] = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (PROBES[i]) begin
      pin_on   = PROBES[i].pinned;
      pin_want = PROBES[i].want;
      send_sample(PROBES[i].level, PROBES[i].now);
    end
    pin_on = 1'b0;
    t_ms   = $urandom();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: next_times = '{16'd0, 16'd0, 16'd0};
        1: next_times = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: next_times = '{cfg_word_t'($urandom_range(0, 20)),
                          cfg_word_t'($urandom_range(20, 400)),
                          cfg_word_t'($urandom_range(10, 200))};
        3: next_times = '{DEBOUNCE_RESET, LONG_PRESS_RESET, CLICK_GAP_RESET};
        default: next_times = '{cfg_word_t'($urandom()), cfg_word_t'($urandom()),
                                cfg_word_t'($urandom())};
      endcase
      write_reg(REG_UNUSED, cfg_word_t'($urandom()));  // must be dropped
      write_reg(REG_DEBOUNCE, next_times.debounce_ms);
      write_reg(REG_LONG_PRESS, next_times.long_press_ms);
      write_reg(REG_CLICK_GAP, next_times.click_gap_ms);
      cfg_ch.valid = 1'b0;

      phase_end = samples_taken + PHASE_ITEMS;
      while (samples_taken < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          // bounce noise and stamp jumps
          db = 32'(times_cfg.debounce_ms);
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) t_ms = $urandom();
            step_to(1'($urandom_range(0, 1)), $urandom_range(0, 2 * db + 2));
          end
        end else begin
          play_gesture();
        end
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    $display("%0d samples over %0d timing settings, %0d register writes",
             samples_taken, NUM_PHASES + 1, reg_writes);
    $display("single %0d, double %0d, triple %0d, long %0d, mismatches %0d",
             gesture_hits[CLICK_SINGLE], gesture_hits[CLICK_DOUBLE],
             gesture_hits[CLICK_TRIPLE], gesture_hits[GESTURE_LONG], errors);
    if (errors == 0 && gestures_due.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bgc_pkg.sv
hw/rtl/bgc_if.sv
hw/rtl/bgc_cfg_regs.sv
hw/rtl/bgc_core.sv
hw/rtl/button_gesture_classifier.sv
test/testbench.sv
